### rtl/response_line_tokenizer_unit_assert.svh
// Assertion macros used by the tokenizer result queue.
`ifndef RESPONSE_LINE_TOKENIZER_UNIT_ASSERT_SVH
`define RESPONSE_LINE_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

### rtl/rlt_pkg.sv
// Shared types and constants of the response line tokenizer.
package rlt_pkg;

  localparam int KIND_W = 4;
  localparam int VALUE_W = 32;
  localparam int MODE_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int KW_COUNT = 6;

  localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd1;
  localparam logic [KIND_W-1:0] KIND_SPACE  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_STAR   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_EOL    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd5;
  localparam logic [KIND_W-1:0] KIND_SBYTE  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SEND   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_KW0    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_FAIL   = 4'd14;

  localparam logic [MODE_W-1:0] MODE_NORMAL     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_CR         = 4'd1;
  localparam logic [MODE_W-1:0] MODE_QSTR       = 4'd2;
  localparam logic [MODE_W-1:0] MODE_QESC       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_LITNUM     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_LITCR      = 4'd5;
  localparam logic [MODE_W-1:0] MODE_LITLF      = 4'd6;
  localparam logic [MODE_W-1:0] MODE_LITDATA    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_NUMBER     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_ATOM       = 4'd9;
  localparam logic [MODE_W-1:0] MODE_RECOVER    = 4'd10;
  localparam logic [MODE_W-1:0] MODE_RECOVER_CR = 4'd11;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ASCII_MAX = 8'h7F;

  // Keyword letters, first letter in the low byte.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0000_6B6F,  // ok
    64'h0000_0000_0000_6F6E,  // no
    64'h0000_0000_0065_7962,  // bye
    64'h0000_6576_6974_6361,  // active
    64'h6C61_7272_6566_6572,  // referral
    64'h0000_0000_6C73_6173   // sasl
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd2, 4'd3, 4'd6, 4'd8, 4'd4};

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } rlt_res_t;

  typedef struct packed {
    logic     v0;
    logic     v1;
    rlt_res_t res0;
    rlt_res_t res1;
  } rlt_push_t;

endpackage

### rtl/rlt_lexer.sv
// Lexer state and per-byte decision logic.
module rlt_lexer #(
  parameter int MAX_TEXT_LENGTH = 4095,
  parameter int COUNT_BITS = 32,
  parameter int ATOM_STORE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              end_of_input,
  output rlt_pkg::rlt_push_t push
);
  import rlt_pkg::*;

  localparam int LEN_W = $clog2(MAX_TEXT_LENGTH + 1);
  localparam int AIDX_W = $clog2(ATOM_STORE);

  logic [MODE_W-1:0]     mode, mode_next;
  logic [COUNT_BITS-1:0] digit_count, digit_count_next;
  logic [LEN_W-1:0]      string_length, string_length_next;
  logic [LEN_W-1:0]      atom_length, atom_length_next;
  logic [7:0]            atom_letters [ATOM_STORE];

  logic              wr_en;
  logic [AIDX_W-1:0] wr_idx;
  logic [7:0]        wr_data;

  logic [7:0] ch, ch_low;
  logic       is_letter, is_upper, is_digit;
  logic [MODE_W-1:0] fail_mode;

  logic              nb_emit, nb_atom, nb_qstr, nb_lit, nb_num;
  logic [KIND_W-1:0] nb_kind;
  logic [MODE_W-1:0] nb_mode;
  logic              use_nb, nb_slot;

  logic [COUNT_BITS+3:0] prod;
  logic                  overflow;
  logic [COUNT_BITS-1:0] dc_dec;

  logic              kw_found;
  logic [KIND_W-1:0] kw_kind;
  logic              kw_hit;

  logic               e0_v, e1_v;
  logic [KIND_W-1:0]  e0_k, e1_k;
  logic [VALUE_W-1:0] e0_val, e1_val;

  assign ch = data_byte;
  assign is_upper = (ch >= 8'h41) && (ch <= 8'h5A);
  assign is_letter = is_upper || ((ch >= 8'h61) && (ch <= 8'h7A));
  assign ch_low = is_upper ? (ch | 8'h20) : ch;
  assign is_digit = (ch >= CH_ZERO) && (ch <= 8'h39);
  assign fail_mode = (ch == CH_CR) ? MODE_RECOVER_CR : MODE_RECOVER;

  assign prod = ({4'b0, digit_count} << 3) + ({4'b0, digit_count} << 1)
              + (COUNT_BITS + 4)'(ch - CH_ZERO);
  assign overflow = |prod[COUNT_BITS+3:COUNT_BITS];
  assign dc_dec = digit_count - COUNT_BITS'(1);

  always_comb begin
    kw_found = 1'b0;
    kw_kind = KIND_KW0;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_hit = (32'(atom_length) == 32'(KW_LEN[k]));
      for (int i = 0; i < 8; i++) begin
        if (i < int'(KW_LEN[k]) && atom_letters[i] != KW_TEXT[k][8*i +: 8]) begin
          kw_hit = 1'b0;
        end
      end
      if (kw_hit && !kw_found) begin
        kw_found = 1'b1;
        kw_kind = KIND_KW0 + KIND_W'(k);
      end
    end
  end

  always_comb begin
    nb_emit = 1'b0;
    nb_kind = KIND_LPAREN;
    nb_mode = MODE_NORMAL;
    nb_atom = 1'b0;
    nb_qstr = 1'b0;
    nb_lit = 1'b0;
    nb_num = 1'b0;
    if (is_letter) begin
      nb_mode = MODE_ATOM;
      nb_atom = 1'b1;
    end else begin
      case (ch)
        CH_LPAREN: begin nb_emit = 1'b1; nb_kind = KIND_LPAREN; end
        CH_RPAREN: begin nb_emit = 1'b1; nb_kind = KIND_RPAREN; end
        CH_SPACE:  begin nb_emit = 1'b1; nb_kind = KIND_SPACE; end
        CH_STAR:   begin nb_emit = 1'b1; nb_kind = KIND_STAR; end
        CH_QUOTE:  begin nb_mode = MODE_QSTR; nb_qstr = 1'b1; end
        CH_LBRACE: begin nb_mode = MODE_LITNUM; nb_lit = 1'b1; end
        CH_CR:     nb_mode = MODE_CR;
        CH_LF:     begin nb_emit = 1'b1; nb_kind = KIND_EOL; end
        default: begin
          if (is_digit) begin
            nb_mode = MODE_NUMBER;
            nb_num = 1'b1;
          end else begin
            nb_emit = 1'b1;
            nb_kind = KIND_FAIL;
            nb_mode = MODE_RECOVER;
          end
        end
      endcase
    end
  end

  always_comb begin
    mode_next = mode;
    digit_count_next = digit_count;
    string_length_next = string_length;
    atom_length_next = atom_length;
    wr_en = 1'b0;
    wr_idx = '0;
    wr_data = ch_low;
    use_nb = 1'b0;
    nb_slot = 1'b0;
    e0_v = 1'b0;
    e0_k = KIND_FAIL;
    e0_val = '0;
    e1_v = 1'b0;
    e1_k = KIND_FAIL;
    e1_val = '0;
    if (end_of_input) begin
      e0_v = 1'b1;
      mode_next = MODE_NORMAL;
      digit_count_next = '0;
      string_length_next = '0;
      atom_length_next = '0;
    end else begin
      case (mode)
        MODE_NORMAL: use_nb = 1'b1;
        MODE_CR: begin
          if (ch == CH_LF) begin
            e0_v = 1'b1; e0_k = KIND_EOL; mode_next = MODE_NORMAL;
          end else begin
            e0_v = 1'b1; mode_next = fail_mode;
          end
        end
        MODE_QSTR: begin
          if (ch == CH_QUOTE) begin
            e0_v = 1'b1; e0_k = KIND_SEND; mode_next = MODE_NORMAL;
          end else if (ch == 8'h00 || ch > CH_ASCII_MAX
                       || string_length >= LEN_W'(MAX_TEXT_LENGTH)) begin
            e0_v = 1'b1; mode_next = fail_mode;
          end else if (ch == CH_BSLASH) begin
            mode_next = MODE_QESC;
          end else begin
            e0_v = 1'b1; e0_k = KIND_SBYTE; e0_val = VALUE_W'(ch);
            string_length_next = string_length + LEN_W'(1);
          end
        end
        MODE_QESC: begin
          if (ch == CH_QUOTE || ch == CH_BSLASH) begin
            e0_v = 1'b1; e0_k = KIND_SBYTE; e0_val = VALUE_W'(ch);
            string_length_next = string_length + LEN_W'(1);
            mode_next = MODE_QSTR;
          end else begin
            e0_v = 1'b1; mode_next = fail_mode;
          end
        end
        MODE_LITNUM: begin
          if (is_digit) begin
            if (overflow) begin
              e0_v = 1'b1; mode_next = fail_mode;
            end else begin
              digit_count_next = prod[COUNT_BITS-1:0];
            end
          end else if (ch == CH_RBRACE) begin
            mode_next = MODE_LITCR;
          end else begin
            e0_v = 1'b1; mode_next = fail_mode;
          end
        end
        MODE_LITCR: begin
          if (ch == CH_CR) mode_next = MODE_LITLF;
          else begin
            e0_v = 1'b1; mode_next = fail_mode;
          end
        end
        MODE_LITLF: begin
          if (ch != CH_LF) begin
            e0_v = 1'b1; mode_next = fail_mode;
          end else if (digit_count == '0) begin
            e0_v = 1'b1; e0_k = KIND_SEND; mode_next = MODE_NORMAL;
          end else begin
            mode_next = MODE_LITDATA;
          end
        end
        MODE_LITDATA: begin
          e0_v = 1'b1; e0_k = KIND_SBYTE; e0_val = VALUE_W'(ch);
          digit_count_next = dc_dec;
          if (dc_dec == '0) begin
            e1_v = 1'b1; e1_k = KIND_SEND; mode_next = MODE_NORMAL;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            if (overflow) begin
              e0_v = 1'b1; mode_next = fail_mode;
            end else begin
              digit_count_next = prod[COUNT_BITS-1:0];
            end
          end else begin
            e0_v = 1'b1; e0_k = KIND_NUMBER; e0_val = VALUE_W'(digit_count);
            use_nb = 1'b1; nb_slot = 1'b1;
          end
        end
        MODE_ATOM: begin
          if (is_letter) begin
            if (atom_length >= LEN_W'(MAX_TEXT_LENGTH)) begin
              e0_v = 1'b1; mode_next = fail_mode;
            end else begin
              if (32'(atom_length) < 32'(ATOM_STORE)) begin
                wr_en = 1'b1;
                wr_idx = AIDX_W'(atom_length);
              end
              atom_length_next = atom_length + LEN_W'(1);
            end
          end else if (kw_found) begin
            e0_v = 1'b1; e0_k = kw_kind;
            use_nb = 1'b1; nb_slot = 1'b1;
          end else begin
            e0_v = 1'b1; mode_next = fail_mode;
          end
        end
        MODE_RECOVER_CR: begin
          if (ch == CH_LF) begin
            e0_v = 1'b1; e0_k = KIND_EOL; mode_next = MODE_NORMAL;
          end else if (ch != CH_CR) begin
            mode_next = MODE_RECOVER;
          end
        end
        default: mode_next = fail_mode;
      endcase
      if (use_nb) begin
        mode_next = nb_mode;
        if (nb_atom) begin
          wr_en = 1'b1;
          wr_idx = '0;
          atom_length_next = LEN_W'(1);
        end
        if (nb_qstr) string_length_next = '0;
        if (nb_lit) digit_count_next = '0;
        if (nb_num) digit_count_next = COUNT_BITS'(ch - CH_ZERO);
        if (nb_emit) begin
          if (nb_slot) begin
            e1_v = 1'b1; e1_k = nb_kind;
          end else begin
            e0_v = 1'b1; e0_k = nb_kind;
          end
        end
      end
    end
  end

  always_comb begin
    push.v0 = take && e0_v;
    push.v1 = take && e1_v;
    push.res0.kind = e0_k;
    push.res0.value = e0_val;
    push.res0.last = !e1_v;
    push.res1.kind = e1_k;
    push.res1.value = e1_val;
    push.res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      digit_count <= '0;
      string_length <= '0;
      atom_length <= '0;
    end else if (take) begin
      mode <= mode_next;
      digit_count <= digit_count_next;
      string_length <= string_length_next;
      atom_length <= atom_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en && !end_of_input) begin
      atom_letters[wr_idx] <= wr_data;
    end
  end

endmodule

### rtl/rlt_outq.sv
// Result queue that takes up to two results per cycle and hands out one per cycle while out_stall is low.
`include "response_line_tokenizer_unit_assert.svh"

module rlt_outq (
  input  logic               clk,
  input  logic               rst,
  input  rlt_pkg::rlt_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output rlt_pkg::rlt_res_t  head
);
  import rlt_pkg::*;

  rlt_res_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic                pop;

  assign room = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop = out_valid && !out_stall;
  assign head = entries[rd_ptr];

  always_comb begin
    count_next = count + QCNT_W'(push.v0) + QCNT_W'(push.v1) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push.v0 && push.v1) wr_ptr <= wr_ptr + QPTR_W'(2);
      else if (push.v0) wr_ptr <= wr_ptr + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) entries[wr_ptr] <= push.res0;
    if (push.v1) entries[wr_ptr + QPTR_W'(1)] <= push.res1;
  end

  `RLT_ASSERT_NOW(a_second_needs_first, push.v1, push.v0)
  `RLT_ASSERT_NOW(a_push_has_space, push.v0, count <= QCNT_W'(QUEUE_DEPTH - 2))
  `RLT_ASSERT_NEXT(a_pair_grows_by_two, push.v1 && !pop, count == $past(count) + QCNT_W'(2))

endmodule

### rtl/response_line_tokenizer_unit.sv
// Top level of the response line tokenizer: input register, lexer and result queue.
//
// Input channel (in_valid, in_stall, data_byte, end_of_input) carries one byte of a
// protocol response per transfer; end_of_input flags a closed stream and makes the
// byte ignored. Output channel (out_valid, out_stall, kind, value, last) carries one
// token per transfer; last marks the final token caused by an input byte. A byte
// can cause zero, one or two tokens.
// A byte taken into the input register is lexed once the result queue has room, and
// its tokens are written into the queue and offered from its head.
// Throughput: one byte per cycle while each byte yields at most one token and
// out_stall stays low; the two tokens of a byte leave one after the other through
// the single output port, and the four-entry result queue paces the input through in_stall.
// A stalled receiver fills the result queue; once fewer than two entries are free
// the lexer holds the registered byte and in_stall rises.
// Reset (rst, synchronous): lexer returns to normal mode with its counters
// cleared, queue and input register are emptied. No clearing pass is needed.
module response_line_tokenizer_unit #(
  parameter int MAX_TEXT_LENGTH = 4095,
  parameter int COUNT_BITS = 32,
  parameter int ATOM_STORE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [31:0] value,
  output logic        last
);
  import rlt_pkg::*;

  logic       in_full;
  logic [7:0] byte_q;
  logic       eoi_q;
  logic       room;
  logic       take;
  rlt_push_t  push;
  rlt_res_t   head;

  assign take = in_full && room;
  assign in_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= data_byte;
      eoi_q <= end_of_input;
    end
  end

  rlt_lexer #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH),
    .COUNT_BITS(COUNT_BITS),
    .ATOM_STORE(ATOM_STORE)
  ) u_lexer (
    .clk(clk),
    .rst(rst),
    .take(take),
    .data_byte(byte_q),
    .end_of_input(eoi_q),
    .push(push)
  );

  rlt_outq u_outq (
    .clk(clk),
    .rst(rst),
    .push(push),
    .room(room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head(head)
  );

  assign kind = head.kind;
  assign value = head.value;
  assign last = head.last;

endmodule

### test/rlt_checker.sv
// Checker for the response line tokenizer: watches both channels, predicts tokens, compares.
`timescale 1ns / 1ps

module rlt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  kind,
  input  logic [31:0] value,
  input  logic        last,
  output int          fail_count,
  output int          tokens_due
);
  import rlt_pkg::*;

  localparam int unsigned TEXT_MAX = 4095;
  localparam int unsigned ATOM_SLOTS = 8;
  localparam logic [63:0] COUNT_MAX = 64'h0000_0000_FFFF_FFFF;

  logic [MODE_W-1:0] mode;
  logic [63:0]       num;
  int unsigned       qlen;
  logic [7:0]        letters [ATOM_SLOTS];
  int unsigned       alen;

  rlt_res_t token_q [$];
  rlt_res_t step_q [$];
  rlt_res_t want;
  int       errs;

  initial begin
    fail_count = 0;
    tokens_due = 0;
    errs = 0;
  end

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_ZERO + 8'd9;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
  endfunction

  function automatic int match_keyword();
    int   hit;
    logic same;
    hit = -1;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (hit < 0 && alen == KW_LEN[k]) begin
        same = 1'b1;
        for (int i = 0; i < KW_LEN[k]; i++)
          if (letters[i] != KW_TEXT[k][8*i +: 8]) same = 1'b0;
        if (same) hit = k;
      end
    end
    return hit;
  endfunction

  task automatic push_token(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
    rlt_res_t tok;
    tok.kind = k;
    tok.value = v;
    tok.last = 1'b0;
    if (step_q.size() < 2) step_q.push_back(tok);
  endtask

  task automatic enter_recovery(input logic [7:0] ch);
    push_token(KIND_FAIL, '0);
    mode = (ch == CH_CR) ? MODE_RECOVER_CR : MODE_RECOVER;
  endtask

  task automatic take_digit(input logic [7:0] ch);
    logic [63:0] d;
    d = 64'(ch - CH_ZERO);
    if (num > (COUNT_MAX - d) / 10) enter_recovery(ch);
    else num = num * 10 + d;
  endtask

  task automatic lex_normal(input logic [7:0] ch);
    if (is_alpha(ch)) begin
      mode = MODE_ATOM;
      letters[0] = fold(ch);
      alen = 1;
    end else begin
      case (ch)
        CH_LPAREN: push_token(KIND_LPAREN, '0);
        CH_RPAREN: push_token(KIND_RPAREN, '0);
        CH_SPACE:  push_token(KIND_SPACE, '0);
        CH_STAR:   push_token(KIND_STAR, '0);
        CH_QUOTE: begin
          mode = MODE_QSTR;
          qlen = 0;
        end
        CH_LBRACE: begin
          num = '0;
          mode = MODE_LITNUM;
        end
        CH_CR: mode = MODE_CR;
        CH_LF: push_token(KIND_EOL, '0);
        default: begin
          if (is_digit(ch)) begin
            num = 64'(ch - CH_ZERO);
            mode = MODE_NUMBER;
          end else begin
            enter_recovery(ch);
          end
        end
      endcase
    end
  endtask

  task automatic lex_item(input logic [7:0] ch, input logic eoi);
    rlt_res_t tok;
    int       kw;
    step_q.delete();
    if (eoi) begin
      push_token(KIND_FAIL, '0);
      mode = MODE_NORMAL;
      num = '0;
      qlen = 0;
      alen = 0;
    end else begin
      case (mode)
        MODE_NORMAL: lex_normal(ch);
        MODE_CR: begin
          if (ch == CH_LF) begin
            push_token(KIND_EOL, '0);
            mode = MODE_NORMAL;
          end else begin
            enter_recovery(ch);
          end
        end
        MODE_QSTR: begin
          if (ch == CH_QUOTE) begin
            push_token(KIND_SEND, '0);
            mode = MODE_NORMAL;
          end else if (ch == 8'h00 || ch > CH_ASCII_MAX) begin
            enter_recovery(ch);
          end else if (qlen >= TEXT_MAX) begin
            enter_recovery(ch);
          end else if (ch == CH_BSLASH) begin
            mode = MODE_QESC;
          end else begin
            push_token(KIND_SBYTE, {24'b0, ch});
            qlen++;
          end
        end
        MODE_QESC: begin
          if (ch == CH_QUOTE || ch == CH_BSLASH) begin
            push_token(KIND_SBYTE, {24'b0, ch});
            qlen++;
            mode = MODE_QSTR;
          end else begin
            enter_recovery(ch);
          end
        end
        MODE_LITNUM: begin
          if (is_digit(ch)) take_digit(ch);
          else if (ch == CH_RBRACE) mode = MODE_LITCR;
          else enter_recovery(ch);
        end
        MODE_LITCR: begin
          if (ch == CH_CR) mode = MODE_LITLF;
          else enter_recovery(ch);
        end
        MODE_LITLF: begin
          if (ch != CH_LF) begin
            enter_recovery(ch);
          end else if (num == 0) begin
            push_token(KIND_SEND, '0);
            mode = MODE_NORMAL;
          end else begin
            mode = MODE_LITDATA;
          end
        end
        MODE_LITDATA: begin
          push_token(KIND_SBYTE, {24'b0, ch});
          num = (num - 1) & COUNT_MAX;
          if (num == 0) begin
            push_token(KIND_SEND, '0);
            mode = MODE_NORMAL;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(ch)) begin
            take_digit(ch);
          end else begin
            push_token(KIND_NUMBER, num[31:0]);
            mode = MODE_NORMAL;
            lex_normal(ch);
          end
        end
        MODE_ATOM: begin
          if (is_alpha(ch)) begin
            if (alen >= TEXT_MAX) begin
              enter_recovery(ch);
            end else begin
              if (alen < ATOM_SLOTS) letters[alen] = fold(ch);
              alen++;
            end
          end else begin
            kw = match_keyword();
            if (kw >= 0) begin
              push_token(KIND_KW0 + kw[3:0], '0);
              mode = MODE_NORMAL;
              lex_normal(ch);
            end else begin
              enter_recovery(ch);
            end
          end
        end
        MODE_RECOVER_CR: begin
          if (ch == CH_LF) begin
            push_token(KIND_EOL, '0);
            mode = MODE_NORMAL;
          end else if (ch != CH_CR) begin
            mode = MODE_RECOVER;
          end
        end
        default: mode = (ch == CH_CR) ? MODE_RECOVER_CR : MODE_RECOVER;
      endcase
    end
    foreach (step_q[i]) begin
      tok = step_q[i];
      tok.last = (i == step_q.size() - 1);
      token_q.push_back(tok);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_NORMAL;
      num = '0;
      qlen = 0;
      alen = 0;
      foreach (letters[i]) letters[i] = '0;
      token_q.delete();
    end else begin
      if (in_valid && !in_stall) lex_item(data_byte, end_of_input);
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("token with nothing due: kind %0d value %0h last %0b", kind, value, last);
          errs++;
        end else begin
          want = token_q.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            errs++;
          end
          if (value !== want.value) begin
            $error("value: expected %0h, actual %0h", want.value, value);
            errs++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    tokens_due <= token_q.size();
  end

endmodule

### test/tb_response_line_tokenizer_unit.sv
// Testbench top for the response line tokenizer: stimulus, idle and stall phases and verdict.
`timescale 1ns / 1ps

module tb_response_line_tokenizer_unit;
  import rlt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  kind;
  logic [31:0] value;
  logic        last;
  int          fail_count;
  int          tokens_due;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;
  int quiet_cycles = 0;
  int quota;

  response_line_tokenizer_unit u_top (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .end_of_input,
    .out_valid, .out_stall, .kind, .value, .last
  );

  rlt_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .end_of_input,
    .out_valid, .out_stall, .kind, .value, .last, .fail_count, .tokens_due
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("** response_line_tokenizer_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
  endtask

  task automatic send_letters(input int n);
    logic [7:0] ch;
    for (int i = 0; i < n; i++) begin
      ch = 8'("a" + $urandom_range(25));
      if ($urandom_range(1)) ch = ch - 8'h20;
      send_byte(ch, 1'b0);
    end
  endtask

  task automatic send_line();
    int         n_tok;
    int         pick;
    int         len;
    int         k;
    logic [7:0] ch;
    n_tok = $urandom_range(1, 6);
    if ($urandom_range(1)) send_text("* ");
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        k = $urandom_range(KW_COUNT - 1);
        for (int i = 0; i < KW_LEN[k]; i++) begin
          ch = KW_TEXT[k][8*i +: 8];
          if ($urandom_range(1)) ch = ch - 8'h20;
          send_byte(ch, 1'b0);
        end
      end else if (pick < 34) begin
        case ($urandom_range(9))
          0: send_text("4294967295");
          1: send_text("4294967296");
          2: send_text("0");
          default: begin
            len = $urandom_range(1, 11);
            for (int i = 0; i < len; i++) send_byte(8'(CH_ZERO + $urandom_range(9)), 1'b0);
          end
        endcase
      end else if (pick < 50) begin
        send_byte(CH_QUOTE, 1'b0);
        len = $urandom_range(6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(19))
            0: begin
              send_byte(CH_BSLASH, 1'b0);
              send_byte($urandom_range(1) ? CH_QUOTE : CH_BSLASH, 1'b0);
            end
            1: begin
              case ($urandom_range(2))
                0: send_byte(8'h00, 1'b0);
                1: send_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
                default: send_text("\\n");
              endcase
            end
            default: begin
              ch = 8'($urandom_range(1, 127));
              if (ch == CH_QUOTE || ch == CH_BSLASH) ch = "q";
              send_byte(ch, 1'b0);
            end
          endcase
        end
        send_byte(CH_QUOTE, 1'b0);
      end else if (pick < 64) begin
        len = $urandom_range(5);
        case ($urandom_range(9))
          0: send_text("{4294967296}");
          1: begin
            send_byte(CH_LBRACE, 1'b0);
            send_byte(8'(CH_ZERO + len), 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
            send_byte(CH_RBRACE, 1'b0);
          end
          default: begin
            send_byte(CH_LBRACE, 1'b0);
            if ($urandom_range(3) == 0) send_byte(CH_ZERO, 1'b0);
            send_byte(8'(CH_ZERO + len), 1'b0);
            send_byte(CH_RBRACE, 1'b0);
          end
        endcase
        send_crlf();
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), 1'b0);
      end else if (pick < 72) begin
        case ($urandom_range(2))
          0: send_byte(CH_LPAREN, 1'b0);
          1: send_byte(CH_RPAREN, 1'b0);
          default: send_byte(CH_SPACE, 1'b0);
        endcase
      end else if (pick < 76) begin
        send_byte(CH_STAR, 1'b0);
      end else if (pick < 82) begin
        send_byte(8'($urandom_range(255)), 1'b0);
      end else if (pick < 88) begin
        send_letters($urandom_range(1, 9));
      end else if (pick < 91) begin
        send_byte(8'($urandom_range(255)), 1'b1);
      end else if (pick < 95) begin
        send_byte(CH_CR, 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        send_byte(CH_CR, 1'b0);
        send_crlf();
      end
      if ($urandom_range(9) < 6) send_byte(CH_SPACE, 1'b0);
    end
    if ($urandom_range(9) == 0) send_byte(CH_LF, 1'b0);
    else send_crlf();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("* ok (12 \"a\\\"\") {1}");
    send_crlf();
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(8'h00, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 50;
        end
        default: begin
          idle_pct = 24;
          stall_pct = 24;
        end
      endcase
      quota = sent_items + 100;
      while (sent_items < quota) send_line();
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (tokens_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && tokens_due == 0) begin
      $display("** response_line_tokenizer_unit: PASSED **");
    end else begin
      $display("** response_line_tokenizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
